// ----- hdl/pidq_pkg.sv -----
`timescale 1ns / 1ps

package pidq_pkg;

	// Fixed field widths of the stream payload.
	localparam int ACT_W   = 16;
	localparam int WORD_W  = 32;
	localparam int COEF_W  = 16;
	localparam int ACC_W   = 48;
	localparam int S_DATA_W = ACT_W + WORD_W + 2 * COEF_W;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture an input beat
		logic weight_en; // form code*scale + bias
		logic prod_en;   // form activation * weight
		logic acc_en;    // add into the accumulator, emit on the last element
	} pidq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last; // the captured element closes the dot product
	} pidq_status_t;

endpackage

// ----- hdl/pidq_datapath.sv -----
`timescale 1ns / 1ps

module pidq_datapath #(
	parameter int CODE_BITS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pidq_pkg::pidq_cmd_t               cmd,
	input  logic signed [pidq_pkg::ACT_W-1:0]  activation,
	input  logic [pidq_pkg::WORD_W-1:0]        packed_word,
	input  logic signed [pidq_pkg::COEF_W-1:0] group_scale,
	input  logic signed [pidq_pkg::COEF_W-1:0] group_bias,
	input  logic                              last_element,
	output pidq_pkg::pidq_status_t             status,
	output logic signed [pidq_pkg::ACC_W-1:0]  dot_sum,
	output logic                              overflowed
);

	import pidq_pkg::*;

	localparam int CODES    = WORD_W / CODE_BITS;
	localparam int POS_W    = $clog2(CODES);
	localparam int SHIFT_W  = $clog2(WORD_W);
	localparam int WEIGHT_W = CODE_BITS + COEF_W + 1;
	localparam int PROD_W   = ACT_W + WEIGHT_W;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(CODES - 1);
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Captured input beat.
	logic signed [ACT_W-1:0]  act_q;
	logic [WORD_W-1:0]        word_q;
	logic signed [COEF_W-1:0] scale_q;
	logic signed [COEF_W-1:0] bias_q;
	logic                     last_q;

	// Dot product state.
	logic signed [ACC_W-1:0] acc_q;
	logic [POS_W-1:0]        pos_q;
	logic                    sat_q;

	// Intermediate stage registers.
	logic signed [WEIGHT_W-1:0] weight_s1;
	logic signed [PROD_W-1:0]   prod_s2;

	logic [SHIFT_W-1:0]         shift_amt;
	logic [WORD_W-1:0]          word_shifted;
	logic [CODE_BITS-1:0]       code;
	logic signed [WEIGHT_W-1:0] code_ext;
	logic signed [WEIGHT_W-1:0] scale_ext;
	logic signed [WEIGHT_W-1:0] bias_ext;
	logic signed [PROD_W-1:0]   act_ext;
	logic signed [PROD_W-1:0]   weight_ext;
	logic signed [ACC_W:0]      sum_wide;
	logic                       sum_ovf;
	logic signed [ACC_W-1:0]    sum_sat;

	// Code selection at the current position.
	always_comb begin
		shift_amt    = SHIFT_W'(pos_q * CODE_BITS);
		word_shifted = word_q >> shift_amt;
		code         = word_shifted[CODE_BITS-1:0];
		code_ext     = {{(WEIGHT_W-CODE_BITS){1'b0}}, code};
		scale_ext    = {{(WEIGHT_W-COEF_W){scale_q[COEF_W-1]}}, scale_q};
		bias_ext     = {{(WEIGHT_W-COEF_W){bias_q[COEF_W-1]}}, bias_q};
		act_ext      = {{(PROD_W-ACT_W){act_q[ACT_W-1]}}, act_q};
		weight_ext   = {{(PROD_W-WEIGHT_W){weight_s1[WEIGHT_W-1]}}, weight_s1};
	end

	// Saturating accumulate: one guard bit catches leaving the 48-bit range.
	always_comb begin
		sum_wide = {acc_q[ACC_W-1], acc_q} + {{(ACC_W+1-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		sum_ovf  = sum_wide[ACC_W] != sum_wide[ACC_W-1];
		if (!sum_ovf) begin
			sum_sat = sum_wide[ACC_W-1:0];
		end else if (sum_wide[ACC_W]) begin
			sum_sat = ACC_MIN;
		end else begin
			sum_sat = ACC_MAX;
		end
	end

	// Input capture and arithmetic stages.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= activation;
			word_q  <= packed_word;
			scale_q <= group_scale;
			bias_q  <= group_bias;
			last_q  <= last_element;
		end
		if (cmd.weight_en) begin
			weight_s1 <= code_ext * scale_ext + bias_ext;
		end
		if (cmd.prod_en) begin
			prod_s2 <= act_ext * weight_ext;
		end
		if (cmd.acc_en && last_q) begin
			dot_sum    <= sum_sat;
			overflowed <= sat_q | sum_ovf;
		end
	end

	// Accumulator, code position and saturation flag; cleared after the last element.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.acc_en) begin
			if (last_q) begin
				acc_q <= '0;
				pos_q <= '0;
				sat_q <= 1'b0;
			end else begin
				acc_q <= sum_sat;
				pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
				sat_q <= sat_q | sum_ovf;
			end
		end
	end

	assign status.last = last_q;

endmodule

// ----- hdl/pidq_controller.sv -----
`timescale 1ns / 1ps

module pidq_controller (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  pidq_pkg::pidq_status_t status,
	output pidq_pkg::pidq_cmd_t    cmd
);

	import pidq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WEIGHT,
		ST_PROD,
		ST_ACC
	} state_t;

	state_t state_q;
	logic   acc_go;

	// The accumulate step may emit only when the output register is free.
	assign acc_go   = (state_q == ST_ACC) && (!status.last || !m_tvalid || m_tready);
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load      = s_tvalid && s_tready;
		cmd.weight_en = (state_q == ST_WEIGHT);
		cmd.prod_en   = (state_q == ST_PROD);
		cmd.acc_en    = acc_go;
	end

	// Sequencer and output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			// A new sum raises valid; otherwise valid holds until the beat is taken.
			m_tvalid <= (acc_go && status.last) || (m_tvalid && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_WEIGHT;
					end
				end
				ST_WEIGHT: begin
					state_q <= ST_PROD;
				end
				ST_PROD: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (acc_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/packed_int4_dequant_dot_product_core.sv -----
`timescale 1ns / 1ps

// Dequantizing dot product over packed low-bit weight codes. Each input beat carries one
// Q8.8 activation, the 32-bit word holding the current weight code, that code's Q8.8 group
// scale and bias, and tlast on the final element. The code is picked from the word by an
// internal position counter that wraps after 32/CODE_BITS codes, dequantized as
// code*scale + bias at full precision, multiplied by the activation and added into a 48-bit
// Q.16 accumulator that clamps on overflow. On the tlast beat one output beat is produced with
// the sum in tdata and the saturation flag in tuser, and the accumulator, position and flag
// clear. The caller must feed the right group scale and bias for each element. An element
// passes four steps: capture, weight multiply, activation multiply and accumulate run one after
// another through a single sequencer, so a new beat is taken only after accumulate. A finished
// sum waits in the output register while the next element is taken; the accumulate step of a
// following tlast beat holds until that register has been read.
module packed_int4_dequant_dot_product_core #(
	parameter int CODE_BITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// activation[15:0], packed_word[47:16], group_scale[63:48], group_bias[79:64]
	input  logic [79:0] s_tdata,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// dot_sum[47:0]
	output logic [47:0] m_tdata,
	// overflowed[0]
	output logic [0:0]  m_tuser
);

	import pidq_pkg::*;

	pidq_cmd_t    cmd;
	pidq_status_t status;

	logic signed [ACC_W-1:0] dot_sum;
	logic                    overflowed;

	pidq_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pidq_datapath #(
		.CODE_BITS (CODE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.activation   (s_tdata[ACT_W-1:0]),
		.packed_word  (s_tdata[ACT_W+WORD_W-1:ACT_W]),
		.group_scale  (s_tdata[ACT_W+WORD_W+COEF_W-1:ACT_W+WORD_W]),
		.group_bias   (s_tdata[S_DATA_W-1:ACT_W+WORD_W+COEF_W]),
		.last_element (s_tlast),
		.status       (status),
		.dot_sum      (dot_sum),
		.overflowed   (overflowed)
	);

	assign m_tdata    = dot_sum;
	assign m_tuser[0] = overflowed;

endmodule
